>>> rtl/core/lsi_pkg.sv
package lsi_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int COORD_BITS = 24;

	localparam int CW  = COORD_BITS;
	localparam int AW  = CW + 1;            // line coefficients a, b
	localparam int PW  = 2 * CW;            // coordinate products
	localparam int CCW = 2 * CW + 1;        // line coefficient c
	localparam int PPW = 2 * AW;            // 25x25 partial products
	localparam int DW  = 2 * AW + 1;        // determinant
	localparam int NW  = 3 * CW + 3;        // Cramer numerators
	localparam int QB  = CW;                // quotient bits below the overflow bit

	localparam logic [CW-1:0] FMASK = CW'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic [CW:0]   UNIT  = (CW+1)'(64'd1 << FRAC_BITS);
	localparam logic [CW-1:0] TOP   = CW'((64'd1 << (CW - 1)) - 64'd1);

	typedef struct packed {
		logic signed [CW-1:0] x1e;
		logic signed [CW-1:0] y1e;
		logic signed [CW-1:0] fx1;
		logic signed [CW-1:0] fy1;
		logic signed [CW-1:0] fx2;
		logic signed [CW-1:0] fy2;
		logic signed [CW:0]   cx1;
		logic signed [CW:0]   cy1;
		logic signed [CW:0]   cx2;
		logic signed [CW:0]   cy2;
		logic                 ep;
	} side_t;

	typedef struct packed {
		logic [NW-1:0] rx;
		logic [NW-1:0] ry;
		logic [QB:0]   qx;
		logic [QB:0]   qy;
		logic [DW-1:0] ud;
		logic          negx;
		logic          negy;
		logic          dz;
		side_t         side;
	} div_t;

	function automatic logic signed [CW-1:0] floor_u(logic signed [CW-1:0] v);
		return $signed(v & ~FMASK);
	endfunction

	function automatic logic signed [CW:0] ceil_u(logic signed [CW-1:0] v);
		logic signed [CW:0] r;
		r = (CW+1)'($signed(v & ~FMASK));
		if ((v & FMASK) != '0)
			r = r + $signed(UNIT);
		return r;
	endfunction

	function automatic logic [CW-1:0] trunc_u(logic signed [CW-1:0] v);
		logic [CW-1:0] t;
		t = v >>> FRAC_BITS;
		if (v[CW-1] && ((v & FMASK) != '0))
			t = t + CW'(1);
		return t;
	endfunction

	function automatic logic signed [NW-1:0] join_pp(logic signed [PPW-1:0] hi,
			logic signed [PPW-1:0] lo);
		return (NW'(hi) <<< CW) + NW'(lo);
	endfunction

	function automatic logic in_box(logic signed [CW:0] q, logic signed [CW-1:0] f,
			logic signed [CW:0] c);
		return (q >= (CW+1)'(f)) && (q <= c);
	endfunction

endpackage

>>> rtl/core/line_segment_intersection.sv
// Pipeline: 5 front stages, 25 divider stages of one quotient bit each, and one
// output register.
// Throughput: one item per cycle; the whole pipeline holds only while the
// output register is full and stalled.
// Reset: arst_n clears all valid bits; payload registers are not reset.
module line_segment_intersection (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pair_valid,
	output logic                          pair_stall,
	input  logic signed [lsi_pkg::CW-1:0] line1_start_x,
	input  logic signed [lsi_pkg::CW-1:0] line1_start_y,
	input  logic signed [lsi_pkg::CW-1:0] line1_end_x,
	input  logic signed [lsi_pkg::CW-1:0] line1_end_y,
	input  logic signed [lsi_pkg::CW-1:0] line2_start_x,
	input  logic signed [lsi_pkg::CW-1:0] line2_start_y,
	input  logic signed [lsi_pkg::CW-1:0] line2_end_x,
	input  logic signed [lsi_pkg::CW-1:0] line2_end_y,
	output logic                          hit_valid,
	input  logic                          hit_stall,
	output logic signed [lsi_pkg::CW-1:0] hit_x,
	output logic signed [lsi_pkg::CW-1:0] hit_y,
	output logic                          found,
	output logic                          via_endpoint
);

	logic          en;
	logic          f_v, d_v;
	lsi_pkg::div_t f_d, d_d;

	assign en         = !(hit_valid && hit_stall);
	assign pair_stall = !en;

	lsi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (pair_valid),
		.x1s    (line1_start_x),
		.y1s    (line1_start_y),
		.x1e    (line1_end_x),
		.y1e    (line1_end_y),
		.x2s    (line2_start_x),
		.y2s    (line2_start_y),
		.x2e    (line2_end_x),
		.y2e    (line2_end_y),
		.out_v  (f_v),
		.out_d  (f_d)
	);

	lsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (f_v),
		.in_d   (f_d),
		.out_v  (d_v),
		.out_d  (d_d)
	);

	lsi_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (d_v),
		.in_d   (d_d),
		.out_v  (hit_valid),
		.hx     (hit_x),
		.hy     (hit_y),
		.fnd    (found),
		.via    (via_endpoint)
	);

endmodule

>>> rtl/core/lsi_front.sv
module lsi_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_v,
	input  logic signed [lsi_pkg::CW-1:0]   x1s,
	input  logic signed [lsi_pkg::CW-1:0]   y1s,
	input  logic signed [lsi_pkg::CW-1:0]   x1e,
	input  logic signed [lsi_pkg::CW-1:0]   y1e,
	input  logic signed [lsi_pkg::CW-1:0]   x2s,
	input  logic signed [lsi_pkg::CW-1:0]   y2s,
	input  logic signed [lsi_pkg::CW-1:0]   x2e,
	input  logic signed [lsi_pkg::CW-1:0]   y2e,
	output logic                            out_v,
	output lsi_pkg::div_t                   out_d
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1
	logic signed [lsi_pkg::AW-1:0]  a1, b1, a2, b2;
	logic signed [lsi_pkg::PW-1:0]  p1, p2, p3, p4;
	lsi_pkg::side_t                 side;
	logic signed [lsi_pkg::CW-1:0]  lox1, hix1, loy1, hiy1, lox2, hix2, loy2, hiy2;

	logic signed [lsi_pkg::AW-1:0]  a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [lsi_pkg::PW-1:0]  p1_s1, p2_s1, p3_s1, p4_s1;
	lsi_pkg::side_t                 side_s1;

	always_comb begin
		a1 = lsi_pkg::AW'(y1e) - lsi_pkg::AW'(y1s);
		b1 = lsi_pkg::AW'(x1s) - lsi_pkg::AW'(x1e);
		a2 = lsi_pkg::AW'(y2e) - lsi_pkg::AW'(y2s);
		b2 = lsi_pkg::AW'(x2s) - lsi_pkg::AW'(x2e);
		p1 = x1e * y1s;
		p2 = x1s * y1e;
		p3 = x2e * y2s;
		p4 = x2s * y2e;
		lox1 = (x1s < x1e) ? x1s : x1e;
		hix1 = (x1s < x1e) ? x1e : x1s;
		loy1 = (y1s < y1e) ? y1s : y1e;
		hiy1 = (y1s < y1e) ? y1e : y1s;
		lox2 = (x2s < x2e) ? x2s : x2e;
		hix2 = (x2s < x2e) ? x2e : x2s;
		loy2 = (y2s < y2e) ? y2s : y2e;
		hiy2 = (y2s < y2e) ? y2e : y2s;
		side.x1e = x1e;
		side.y1e = y1e;
		side.fx1 = lsi_pkg::floor_u(lox1);
		side.fy1 = lsi_pkg::floor_u(loy1);
		side.fx2 = lsi_pkg::floor_u(lox2);
		side.fy2 = lsi_pkg::floor_u(loy2);
		side.cx1 = lsi_pkg::ceil_u(hix1);
		side.cy1 = lsi_pkg::ceil_u(hiy1);
		side.cx2 = lsi_pkg::ceil_u(hix2);
		side.cy2 = lsi_pkg::ceil_u(hiy2);
		side.ep  = (lsi_pkg::trunc_u(x1e) == lsi_pkg::trunc_u(x2s)) &&
			(lsi_pkg::trunc_u(y1e) == lsi_pkg::trunc_u(y2s));
	end

	// stage 2
	logic signed [lsi_pkg::AW-1:0]  a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [lsi_pkg::CCW-1:0] c1_s2, c2_s2;
	logic signed [lsi_pkg::PPW-1:0] dp1_s2, dp2_s2;
	lsi_pkg::side_t                 side_s2;

	// stage 3: partial products, index 0 b1*c2, 1 b2*c1, 2 a2*c1, 3 a1*c2
	logic signed [lsi_pkg::DW-1:0]  d_s3;
	logic signed [lsi_pkg::PPW-1:0] ph_s3 [4];
	logic signed [lsi_pkg::PPW-1:0] pl_s3 [4];
	lsi_pkg::side_t                 side_s3;
	logic signed [lsi_pkg::AW-1:0]  c1h, c1l, c2h, c2l;

	always_comb begin
		c1h = $signed(c1_s2[lsi_pkg::CCW-1:lsi_pkg::CW]);
		c2h = $signed(c2_s2[lsi_pkg::CCW-1:lsi_pkg::CW]);
		c1l = $signed({1'b0, c1_s2[lsi_pkg::CW-1:0]});
		c2l = $signed({1'b0, c2_s2[lsi_pkg::CW-1:0]});
	end

	// stage 4
	logic signed [lsi_pkg::DW-1:0]  d_s4;
	logic signed [lsi_pkg::NW-1:0]  nx_s4, ny_s4;
	lsi_pkg::side_t                 side_s4;

	// stage 5
	lsi_pkg::div_t                  d_s5;
	lsi_pkg::div_t                  nxt5;

	always_comb begin
		nxt5.rx   = nx_s4[lsi_pkg::NW-1] ? lsi_pkg::NW'(-nx_s4) : lsi_pkg::NW'(nx_s4);
		nxt5.ry   = ny_s4[lsi_pkg::NW-1] ? lsi_pkg::NW'(-ny_s4) : lsi_pkg::NW'(ny_s4);
		nxt5.qx   = '0;
		nxt5.qy   = '0;
		nxt5.ud   = d_s4[lsi_pkg::DW-1] ? lsi_pkg::DW'(-d_s4) : lsi_pkg::DW'(d_s4);
		nxt5.negx = nx_s4[lsi_pkg::NW-1] ^ d_s4[lsi_pkg::DW-1];
		nxt5.negy = ny_s4[lsi_pkg::NW-1] ^ d_s4[lsi_pkg::DW-1];
		nxt5.dz   = (d_s4 == '0);
		nxt5.side = side_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1   <= a1;
			b1_s1   <= b1;
			a2_s1   <= a2;
			b2_s1   <= b2;
			p1_s1   <= p1;
			p2_s1   <= p2;
			p3_s1   <= p3;
			p4_s1   <= p4;
			side_s1 <= side;

			a1_s2   <= a1_s1;
			b1_s2   <= b1_s1;
			a2_s2   <= a2_s1;
			b2_s2   <= b2_s1;
			c1_s2   <= lsi_pkg::CCW'(p1_s1) - lsi_pkg::CCW'(p2_s1);
			c2_s2   <= lsi_pkg::CCW'(p3_s1) - lsi_pkg::CCW'(p4_s1);
			dp1_s2  <= a1_s1 * b2_s1;
			dp2_s2  <= a2_s1 * b1_s1;
			side_s2 <= side_s1;

			d_s3     <= lsi_pkg::DW'(dp1_s2) - lsi_pkg::DW'(dp2_s2);
			ph_s3[0] <= b1_s2 * c2h;
			pl_s3[0] <= b1_s2 * c2l;
			ph_s3[1] <= b2_s2 * c1h;
			pl_s3[1] <= b2_s2 * c1l;
			ph_s3[2] <= a2_s2 * c1h;
			pl_s3[2] <= a2_s2 * c1l;
			ph_s3[3] <= a1_s2 * c2h;
			pl_s3[3] <= a1_s2 * c2l;
			side_s3  <= side_s2;

			d_s4    <= d_s3;
			nx_s4   <= lsi_pkg::join_pp(ph_s3[0], pl_s3[0]) -
				lsi_pkg::join_pp(ph_s3[1], pl_s3[1]);
			ny_s4   <= lsi_pkg::join_pp(ph_s3[2], pl_s3[2]) -
				lsi_pkg::join_pp(ph_s3[3], pl_s3[3]);
			side_s4 <= side_s3;

			d_s5    <= nxt5;
		end
	end

	assign out_v = v_s5;
	assign out_d = d_s5;

endmodule

>>> rtl/core/lsi_div.sv
module lsi_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  lsi_pkg::div_t in_d,
	output logic          out_v,
	output lsi_pkg::div_t out_d
);

	// one quotient bit per stage, top bit flags a quotient out of range
	lsi_pkg::div_t st [lsi_pkg::QB+2];
	logic          v  [lsi_pkg::QB+2];

	assign st[0] = in_d;
	assign v[0]  = in_v;

	for (genvar k = 0; k <= lsi_pkg::QB; k++) begin : g_st
		localparam int Sh = lsi_pkg::QB - k;
		logic [lsi_pkg::NW:0] dsh, tx, ty;
		lsi_pkg::div_t        nxt;

		always_comb begin
			dsh = (lsi_pkg::NW+1)'(st[k].ud) << Sh;
			tx  = {1'b0, st[k].rx} - dsh;
			ty  = {1'b0, st[k].ry} - dsh;
			nxt = st[k];
			if (!tx[lsi_pkg::NW]) begin
				nxt.rx     = tx[lsi_pkg::NW-1:0];
				nxt.qx[Sh] = 1'b1;
			end
			if (!ty[lsi_pkg::NW]) begin
				nxt.ry     = ty[lsi_pkg::NW-1:0];
				nxt.qy[Sh] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[k+1] <= 1'b0;
			end else if (en) begin
				v[k+1] <= v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st[k+1] <= nxt;
			end
		end
	end

	assign out_v = v[lsi_pkg::QB+1];
	assign out_d = st[lsi_pkg::QB+1];

endmodule

>>> rtl/core/lsi_back.sv
module lsi_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_v,
	input  lsi_pkg::div_t                 in_d,
	output logic                          out_v,
	output logic signed [lsi_pkg::CW-1:0] hx,
	output logic signed [lsi_pkg::CW-1:0] hy,
	output logic                          fnd,
	output logic                          via
);

	logic signed [lsi_pkg::CW:0] mx, my, qx, qy;
	logic                        hit;
	lsi_pkg::side_t              sd;

	always_comb begin
		sd  = in_d.side;
		mx  = $signed({1'b0, in_d.qx[lsi_pkg::QB-1:0]});
		my  = $signed({1'b0, in_d.qy[lsi_pkg::QB-1:0]});
		qx  = in_d.negx ? -mx : mx;
		qy  = in_d.negy ? -my : my;
		hit = !in_d.dz && !in_d.qx[lsi_pkg::QB] && !in_d.qy[lsi_pkg::QB] &&
			lsi_pkg::in_box(qx, sd.fx1, sd.cx1) && lsi_pkg::in_box(qy, sd.fy1, sd.cy1) &&
			lsi_pkg::in_box(qx, sd.fx2, sd.cx2) && lsi_pkg::in_box(qy, sd.fy2, sd.cy2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (hit) begin
				hx  <= (qx > $signed((lsi_pkg::CW+1)'(lsi_pkg::TOP))) ?
					lsi_pkg::TOP : qx[lsi_pkg::CW-1:0];
				hy  <= (qy > $signed((lsi_pkg::CW+1)'(lsi_pkg::TOP))) ?
					lsi_pkg::TOP : qy[lsi_pkg::CW-1:0];
				fnd <= 1'b1;
				via <= 1'b0;
			end else if (sd.ep) begin
				hx  <= sd.x1e;
				hy  <= sd.y1e;
				fnd <= 1'b1;
				via <= 1'b1;
			end else begin
				hx  <= '0;
				hy  <= '0;
				fnd <= 1'b0;
				via <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/lsi_check.sv
module lsi_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pair_valid,
	input logic                          pair_stall,
	input logic                          hit_valid,
	input logic                          hit_stall,
	input logic signed [lsi_pkg::CW-1:0] hit_x,
	input logic signed [lsi_pkg::CW-1:0] hit_y,
	input logic                          found,
	input logic                          via_endpoint
);

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && !found |-> hit_x == '0 && hit_y == '0 && !via_endpoint)
		else $error("not-found item carries a point");

	a_via_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && via_endpoint |-> found)
		else $error("endpoint item without found");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> hit_valid && hit_stall)
		else $error("input held while output free");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit_stall |=> hit_valid && $stable(hit_x) && $stable(hit_y) &&
		$stable(found) && $stable(via_endpoint))
		else $error("stalled item changed");

endmodule

bind line_segment_intersection lsi_check u_check (.*);

>>> verif/tb_line_segment_intersection.sv
module tb_line_segment_intersection;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic signed [lsi_pkg::CW-1:0] x1s, y1s, x1e, y1e, x2s, y2s, x2e, y2e;
	} pair_t;

	typedef struct packed {
		logic signed [lsi_pkg::CW-1:0] x, y;
		logic                          found, ep;
	} hit_t;

	class crossing_sb;
		hit_t hits_due[$];
		int   errors;

		function bit in_span(wide_t v, wide_t p, wide_t q);
			wide_t lo, hi, fl, cl;
			lo = (p < q) ? p : q;
			hi = (p < q) ? q : p;
			fl = (lo >>> lsi_pkg::FRAC_BITS) <<< lsi_pkg::FRAC_BITS;
			cl = -(((-hi) >>> lsi_pkg::FRAC_BITS) <<< lsi_pkg::FRAC_BITS);
			return (v >= fl) && (v <= cl);
		endfunction

		function logic signed [lsi_pkg::CW-1:0] sat(wide_t v);
			wide_t top;
			top = (wide_t'(1) <<< (lsi_pkg::CW - 1)) - 1;
			if (v > top)
				v = top;
			return v[lsi_pkg::CW-1:0];
		endfunction

		function void note(pair_t p);
			wide_t x1s, y1s, x1e, y1e, x2s, y2s, x2e, y2e;
			wide_t a1, b1, a2, b2, c1, c2, d, x, y, s;
			hit_t h;
			x1s = p.x1s; y1s = p.y1s; x1e = p.x1e; y1e = p.y1e;
			x2s = p.x2s; y2s = p.y2s; x2e = p.x2e; y2e = p.y2e;
			s = wide_t'(1) <<< lsi_pkg::FRAC_BITS;
			a1 = y1e - y1s; b1 = x1s - x1e;
			a2 = y2e - y2s; b2 = x2s - x2e;
			c1 = x1e * y1s - x1s * y1e;
			c2 = x2e * y2s - x2s * y2e;
			d = a1 * b2 - a2 * b1;
			h = '0;
			if (d != 0) begin
				x = (b1 * c2 - b2 * c1) / d;
				y = (a2 * c1 - a1 * c2) / d;
				if (in_span(x, x1s, x1e) && in_span(y, y1s, y1e) &&
						in_span(x, x2s, x2e) && in_span(y, y2s, y2e)) begin
					h.x = sat(x);
					h.y = sat(y);
					h.found = 1'b1;
				end
			end
			if (!h.found && (x1e / s == x2s / s) && (y1e / s == y2s / s)) begin
				h.x = sat(x1e);
				h.y = sat(y1e);
				h.found = 1'b1;
				h.ep = 1'b1;
			end
			hits_due.push_back(h);
		endfunction

		function void check(hit_t got);
			hit_t e;
			if (hits_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result x=%0d y=%0d", got.x, got.y);
				return;
			end
			e = hits_due.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp x=%0d y=%0d f=%b e=%b got x=%0d y=%0d f=%b e=%b",
						e.x, e.y, e.found, e.ep, got.x, got.y, got.found, got.ep);
			end
		endfunction
	endclass

	logic clk = 1'b0, arst_n = 1'b0;
	logic pair_valid = 1'b0, hit_stall = 1'b0;
	pair_t pair = '0;
	logic pair_stall, hit_valid, found, via_endpoint;
	logic signed [lsi_pkg::CW-1:0] hit_x, hit_y;
	bit quiet = 1'b0;
	crossing_sb sb = new();

	line_segment_intersection uut (
		.clk(clk), .arst_n(arst_n),
		.pair_valid(pair_valid), .pair_stall(pair_stall),
		.line1_start_x(pair.x1s), .line1_start_y(pair.y1s),
		.line1_end_x(pair.x1e), .line1_end_y(pair.y1e),
		.line2_start_x(pair.x2s), .line2_start_y(pair.y2s),
		.line2_end_x(pair.x2e), .line2_end_y(pair.y2e),
		.hit_valid(hit_valid), .hit_stall(hit_stall),
		.hit_x(hit_x), .hit_y(hit_y), .found(found), .via_endpoint(via_endpoint)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk)
		if (arst_n && hit_valid && !hit_stall)
			sb.check({hit_x, hit_y, found, via_endpoint});

	always @(negedge clk) begin
		int n;
		if (quiet || !arst_n) begin
			hit_stall <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 8);
			hit_stall <= 1'b1;
			repeat (n) @(negedge clk);
			hit_stall <= 1'b0;
		end else begin
			hit_stall <= 1'b0;
		end
	end

	task automatic send(pair_t p);
		int n;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 8);
			pair_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		pair <= p;
		pair_valid <= 1'b1;
		do
			@(posedge clk);
		while (pair_stall);
		sb.note(p);
		@(negedge clk);
	endtask

	function automatic logic signed [lsi_pkg::CW-1:0] rnd_coord();
		return lsi_pkg::CW'($urandom);
	endfunction

	function automatic logic signed [lsi_pkg::CW-1:0] near(logic signed [lsi_pkg::CW-1:0] c,
			int r);
		return c + lsi_pkg::CW'($urandom_range(0, 2 * r) - r);
	endfunction

	function automatic pair_t rnd_pair();
		pair_t p;
		logic signed [lsi_pkg::CW-1:0] cx, cy;
		int r, dx1, dy1, dx2, dy2;
		cx = lsi_pkg::CW'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		cy = lsi_pkg::CW'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		r = 1 << $urandom_range(2, 19);
		dx1 = $urandom_range(0, 2 * r) - r; dy1 = $urandom_range(0, 2 * r) - r;
		dx2 = $urandom_range(0, 2 * r) - r; dy2 = $urandom_range(0, 2 * r) - r;
		case ($urandom_range(0, 9))
			0, 1: p = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
				rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
			2, 3: begin
				p = {near(cx, r), near(cy, r), near(cx, r), near(cy, r),
					near(cx, r), near(cy, r), near(cx, r), near(cy, r)};
				p.x2s = near(p.x1e, 300);
				p.y2s = near(p.y1e, 300);
			end
			4: begin
				p.x1s = cx - dx1; p.y1s = cy - dy1; p.x1e = cx + dx1; p.y1e = cy + dy1;
				p.x2s = cx - dx1 + 5; p.y2s = cy - dy1; p.x2e = cx + dx1 + 5;
				p.y2e = cy + dy1;
			end
			default: begin
				p.x1s = cx - dx1; p.y1s = cy - dy1; p.x1e = cx + dx1; p.y1e = cy + dy1;
				p.x2s = cx - dx2; p.y2s = cy - dy2; p.x2e = cx + dx2; p.y2e = cy + dy2;
			end
		endcase
		return p;
	endfunction

	localparam logic signed [lsi_pkg::CW-1:0] MAXC = lsi_pkg::TOP;
	localparam logic signed [lsi_pkg::CW-1:0] MINC = ~lsi_pkg::TOP;

	initial begin
		pair_t p;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// extremes
		send({MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC});
		send({MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC});
		send({MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC});
		send({MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC});
		send('0);
		// plain crossing, fractional crossing
		send({-24'sd512, 24'sd0, 24'sd512, 24'sd0, 24'sd0, -24'sd512, 24'sd0, 24'sd512});
		send({24'sd0, 24'sd0, 24'sd771, 24'sd333, 24'sd700, 24'sd0, 24'sd5, 24'sd401});
		// crossing on a widened box edge, near top
		send({MAXC - 24'sd700, MAXC, MAXC, MAXC - 24'sd3, MAXC, MAXC - 24'sd900,
			MAXC - 24'sd1, MAXC});
		send({MAXC - 24'sd300, MAXC - 24'sd1, MAXC, MAXC - 24'sd1, MAXC - 24'sd1,
			MAXC - 24'sd300, MAXC - 24'sd1, MAXC});
		// parallel, no shared end
		send({24'sd0, 24'sd0, 24'sd1000, 24'sd1000, 24'sd5000, 24'sd0, 24'sd6000, 24'sd1000});
		// parallel or non-crossing segments with a shared end; truncation toward zero on negatives
		send({24'sd0, 24'sd0, 24'sd1000, 24'sd0, 24'sd1020, 24'sd10, 24'sd3000, 24'sd10});
		send({24'sd0, 24'sd0, -24'sd300, -24'sd10, -24'sd500, -24'sd200, -24'sd900,
			-24'sd400});
		send({24'sd0, 24'sd0, -24'sd100, -24'sd10, 24'sd100, 24'sd10, 24'sd900, 24'sd90});
		// degenerate points
		send({24'sd77, 24'sd77, 24'sd77, 24'sd77, 24'sd77, 24'sd77, 24'sd77, 24'sd77});
		send({24'sd77, 24'sd77, 24'sd77, 24'sd77, 24'sd900, 24'sd900, 24'sd900, 24'sd900});
		for (int i = 0; i < 600; i++)
			send(rnd_pair());
		quiet = 1'b1;
		for (int i = 0; i < 150; i++)
			send(rnd_pair());
		pair_valid <= 1'b0;
		fork : drain
			wait (sb.hits_due.size() == 0);
			begin
				repeat (5000) @(posedge clk);
				sb.errors++;
			end
		join_any
		disable drain;
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.hits_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
